// File: hw/rtl/ibs_pkg.sv
// ibs_pkg: shared types, constants and reset values of the indicator blink sequencer.
// No dependencies; used by every other RTL file of the block.
package ibs_pkg;

  localparam int MAX_CHANNELS = 4;
  localparam int CHANNELS_DEF = 4;
  localparam int LEVEL_W      = 16;
  localparam int TIME_W       = 16;
  localparam int ELAPSED_W    = 32;
  localparam int COUNT_W      = 7;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = 7'd127;
  localparam logic [COUNT_W-1:0] MIN_BLINKS = 7'd2;

  typedef enum logic [1:0] {
    PH_OFF  = 2'd0,
    PH_LIT  = 2'd1,
    PH_DARK = 2'd2
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ON_TIME   = 3'd0,
    CFG_OFF_TIME  = 3'd1,
    CFG_THRESHOLD = 3'd2,
    CFG_INVALID   = 3'd3,
    CFG_LIT       = 3'd4,
    CFG_DARK      = 3'd5,
    CFG_ENABLE    = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic        [TIME_W-1:0]       on_time_ms;
    logic        [TIME_W-1:0]       off_time_ms;
    logic signed [LEVEL_W-1:0]      active_threshold;
    logic signed [LEVEL_W-1:0]      invalid_level;
    logic signed [LEVEL_W-1:0]      lit_level;
    logic signed [LEVEL_W-1:0]      dark_level;
    logic        [MAX_CHANNELS-1:0] channel_enable;
  } cfg_t;

  typedef struct packed {
    logic   step;
    phase_t phase_cur;
    phase_t phase_nxt;
  } phase_ctl_t;

  localparam cfg_t CFG_RESET = '{
    on_time_ms:       16'd400,
    off_time_ms:      16'd400,
    active_threshold: 16'sd0,
    invalid_level:    16'sh8000,
    lit_level:        16'sh7FFF,
    dark_level:       16'sd0,
    channel_enable:   4'b0011
  };

endpackage

// File: hw/rtl/ibs_if.sv
// ibs_in_if / ibs_out_if: valid-ready channel interfaces for tick and result beats.
// Depends on ibs_pkg for field widths.
interface ibs_in_if;
  logic                                 valid;
  logic                                 ready;
  logic        [ibs_pkg::TIME_W-1:0]    delta_ms;
  logic signed [ibs_pkg::LEVEL_W-1:0]   level_a;
  logic signed [ibs_pkg::LEVEL_W-1:0]   level_b;
  logic signed [ibs_pkg::LEVEL_W-1:0]   level_c;
  logic signed [ibs_pkg::LEVEL_W-1:0]   level_d;

  modport source (output valid, delta_ms, level_a, level_b, level_c, level_d, input ready);
  modport sink   (input valid, delta_ms, level_a, level_b, level_c, level_d, output ready);
endinterface

interface ibs_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ibs_pkg::LEVEL_W-1:0]   drive_a;
  logic signed [ibs_pkg::LEVEL_W-1:0]   drive_b;
  logic signed [ibs_pkg::LEVEL_W-1:0]   drive_c;
  logic signed [ibs_pkg::LEVEL_W-1:0]   drive_d;
  logic        [1:0]                    phase;

  modport source (output valid, drive_a, drive_b, drive_c, drive_d, phase, input ready);
  modport sink   (input valid, drive_a, drive_b, drive_c, drive_d, phase, output ready);
endinterface

// File: hw/rtl/ibs_lane.sv
// ibs_lane: per-channel activity detect, participation flag and drive select.
// Depends on ibs_pkg (cfg_t, phase_ctl_t).
module ibs_lane (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ibs_pkg::cfg_t                     cfg,
  input  logic                              enable,
  input  logic signed [ibs_pkg::LEVEL_W-1:0] level,
  input  ibs_pkg::phase_ctl_t               ctl,
  output logic                              active,
  output logic                              joined,
  output logic signed [ibs_pkg::LEVEL_W-1:0] drive
);
  import ibs_pkg::*;

  logic joined_r;
  logic joined_nxt;

  assign active = enable && (level > cfg.active_threshold) && (level != cfg.invalid_level);
  assign joined_nxt = (ctl.phase_cur == PH_LIT) ? (joined_r | active) : active;
  assign joined = joined_r;

  always_comb begin
    drive = level;
    if (joined_nxt) begin
      if (ctl.phase_nxt == PH_DARK) begin
        drive = cfg.dark_level;
      end else if (ctl.phase_nxt == PH_LIT) begin
        drive = cfg.lit_level;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      joined_r <= 1'b0;
    end else if (ctl.step) begin
      joined_r <= joined_nxt;
    end
  end

endmodule

// File: hw/rtl/ibs_ctrl.sv
// ibs_ctrl: shared blink state machine, blink counter and millisecond accumulator.
// Uses the merged lane activity; depends on ibs_pkg.
module ibs_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ibs_pkg::cfg_t                   cfg,
  input  logic                            step,
  input  logic                            any_active,
  input  logic [ibs_pkg::TIME_W-1:0]      delta_ms,
  output ibs_pkg::phase_ctl_t             ctl
);
  import ibs_pkg::*;

  phase_t               phase_r, phase_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic [ELAPSED_W-1:0] elapsed_r, elapsed_nxt;
  logic [ELAPSED_W:0]   sum;
  logic [ELAPSED_W-1:0] elapsed_sat;
  logic [ELAPSED_W-1:0] on_ext;
  logic [ELAPSED_W-1:0] off_ext;

  assign sum         = {1'b0, elapsed_r} + {{(ELAPSED_W + 1 - TIME_W){1'b0}}, delta_ms};
  assign elapsed_sat = sum[ELAPSED_W] ? {ELAPSED_W{1'b1}} : sum[ELAPSED_W-1:0];
  assign on_ext      = {{(ELAPSED_W - TIME_W){1'b0}}, cfg.on_time_ms};
  assign off_ext     = {{(ELAPSED_W - TIME_W){1'b0}}, cfg.off_time_ms};

  always_comb begin
    phase_nxt   = phase_r;
    count_nxt   = count_r;
    elapsed_nxt = elapsed_sat;
    unique case (phase_r)
      PH_OFF: begin
        if (any_active) begin
          count_nxt   = '0;
          elapsed_nxt = '0;
          phase_nxt   = PH_LIT;
        end
      end
      PH_LIT: begin
        if (elapsed_sat > on_ext) begin
          elapsed_nxt = elapsed_sat - on_ext;
          phase_nxt   = PH_DARK;
        end
      end
      PH_DARK: begin
        if (!any_active && (count_r > MIN_BLINKS)) begin
          elapsed_nxt = '0;
          phase_nxt   = PH_OFF;
        end else if (elapsed_sat > off_ext) begin
          if (count_r < COUNT_MAX) begin
            count_nxt = count_r + 1'b1;
          end
          elapsed_nxt = elapsed_sat - off_ext;
          phase_nxt   = PH_LIT;
        end
      end
      default: begin
        phase_nxt = PH_OFF;
      end
    endcase
  end

  assign ctl = '{step: step, phase_cur: phase_r, phase_nxt: phase_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_OFF;
      count_r   <= '0;
      elapsed_r <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      count_r   <= count_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

endmodule

// File: hw/rtl/indicator_blink_sequencer.sv
// indicator_blink_sequencer: turn-signal flasher top level with lanes, controller and
// output register. Depends on ibs_pkg, ibs_if, ibs_lane and ibs_ctrl.
//
// One tick beat is taken per cycle unless output stalls; its result beat appears in the
// output register on the next cycle and a new tick is taken in the same cycle that the
// waiting result is taken, so one beat per cycle is sustained, set by the single
// output register. Each used channel has its own lane for activity detect and drive
// select; the shared controller merges lane activity into the blink state, blink count
// and millisecond timer, all updated in the cycle of acceptance. Configuration is a
// write-only port; write while no beat is in flight.
module indicator_blink_sequencer #(
  parameter int CHANNELS = ibs_pkg::CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  ibs_in_if.sink                            in_ch,
  ibs_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [ibs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ibs_pkg::CFG_W-1:0]         cfg_data
);
  import ibs_pkg::*;

  cfg_t                      cfg_r;
  phase_ctl_t                ctl;
  logic                      step;
  logic                      any_active;
  logic                      out_valid_r;
  logic signed [LEVEL_W-1:0] level   [MAX_CHANNELS];
  logic signed [LEVEL_W-1:0] drive   [MAX_CHANNELS];
  logic signed [LEVEL_W-1:0] drive_r [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0]   active;
  logic [MAX_CHANNELS-1:0]   joined;
  logic [1:0]                phase_r;

  assign level[0] = in_ch.level_a;
  assign level[1] = in_ch.level_b;
  assign level[2] = in_ch.level_c;
  assign level[3] = in_ch.level_d;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign step        = in_ch.valid && in_ch.ready;
  assign any_active  = |active;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ON_TIME:   cfg_r.on_time_ms       <= cfg_data[TIME_W-1:0];
        CFG_OFF_TIME:  cfg_r.off_time_ms      <= cfg_data[TIME_W-1:0];
        CFG_THRESHOLD: cfg_r.active_threshold <= cfg_data[LEVEL_W-1:0];
        CFG_INVALID:   cfg_r.invalid_level    <= cfg_data[LEVEL_W-1:0];
        CFG_LIT:       cfg_r.lit_level        <= cfg_data[LEVEL_W-1:0];
        CFG_DARK:      cfg_r.dark_level       <= cfg_data[LEVEL_W-1:0];
        CFG_ENABLE:    cfg_r.channel_enable   <= cfg_data[MAX_CHANNELS-1:0];
        default: begin
        end
      endcase
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < MAX_CHANNELS; gi++) begin : g_lane
      if (gi < CHANNELS) begin : g_used
        ibs_lane u_lane (
          .clk    (clk),
          .rst_n  (rst_n),
          .cfg    (cfg_r),
          .enable (cfg_r.channel_enable[gi]),
          .level  (level[gi]),
          .ctl    (ctl),
          .active (active[gi]),
          .joined (joined[gi]),
          .drive  (drive[gi])
        );
      end else begin : g_unused
        assign active[gi] = 1'b0;
        assign joined[gi] = 1'b0;
        assign drive[gi]  = level[gi];
      end
    end
  endgenerate

  ibs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .step       (step),
    .any_active (any_active),
    .delta_ms   (in_ch.delta_ms),
    .ctl        (ctl)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      drive_r <= drive;
      phase_r <= ctl.phase_nxt;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.drive_a = drive_r[0];
  assign out_ch.drive_b = drive_r[1];
  assign out_ch.drive_c = drive_r[2];
  assign out_ch.drive_d = drive_r[3];
  assign out_ch.phase   = phase_r;

`ifndef SYNTH
  a_step_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("accepted tick did not produce a result beat");

  a_phase_code_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (phase_r != 2'd3))
    else $error("result beat carries an illegal phase code");

  a_off_none_joined: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.phase_cur == PH_OFF) |-> (joined == '0))
    else $error("channel still joined while sequencer is off");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> !$past(step) || out_valid_r)
    else $error("stalled result beat was lost");
`endif

endmodule
